[design/hwp_pkg.sv]
package hwp_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int MAX_OUTPUTS_DEF = 64;

    // Q16.32 internal word
    localparam int Q_W    = 48;
    // small signed integers: positions, differences, doubled offsets
    localparam int SI_W   = 10;
    // divisor of a scale step (node difference or grid span)
    localparam int DEN_W  = 8;
    // unsigned position / counter width (k reaches MAX_WINDOW + MAX_OUTPUTS - 1)
    localparam int IDX_W  = 7;
    localparam int SMP_W  = 24;
    localparam int PRED_W = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic signed [Q_W-1:0] Q_ONE = 48'sh0001_0000_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic signed [SMP_W-1:0] slope;
        logic                    last_item;
    } hwp_in_t;

    typedef struct packed {
        logic signed [PRED_W-1:0] predicted;
        logic                     last_out;
    } hwp_out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE  = 2'd0,
        CFG_OUTPUT_COUNT = 2'd1,
        CFG_RECONSTRUCT  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_MULQ,
        OP_SCALE
    } alu_op_t;

    typedef struct packed {
        logic                    start;
        alu_op_t                 op;
        logic signed [Q_W-1:0]   opa;
        logic signed [Q_W-1:0]   opb;
        logic signed [SI_W-1:0]  num;
        logic signed [DEN_W-1:0] den;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_ROUND,
        A_DIV,
        A_SAT,
        A_DONE
    } alu_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_J_INIT,
        ST_M_CHECK,
        ST_LAG_GO,
        ST_LAG_WAIT,
        ST_HS_GO,
        ST_HS_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_AX_GO,
        ST_AX_WAIT,
        ST_H1_GO,
        ST_H1_WAIT,
        ST_H2_GO,
        ST_H2_WAIT,
        ST_T1_GO,
        ST_T1_WAIT,
        ST_T2_GO,
        ST_T2_WAIT,
        ST_ROUND,
        ST_EMIT
    } seq_state_t;

    // saturate a one-bit-grown sum back into the Q16.32 range
    function automatic logic signed [Q_W-1:0] q_sat(input logic signed [Q_W:0] s);
        logic signed [Q_W-1:0] r;
        if (s[Q_W] != s[Q_W-1]) begin
            r = s[Q_W] ? Q_MIN : Q_MAX;
        end
        else begin
            r = s[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/hwp_alu.sv]
module hwp_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  hwp_pkg::alu_req_t req,
    output hwp_pkg::alu_rsp_t rsp
);
    import hwp_pkg::*;

    localparam int PROD_W = 2 * Q_W;
    localparam int MAG_W  = 64;
    localparam int CHUNK  = 16;
    localparam int DSTEPS = 8;

    alu_state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    alu_op_t               op_reg;
    logic                  neg_reg;
    logic [Q_W-1:0]        ma_reg, mb_reg;
    logic [DEN_W-1:0]      d_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic signed [Q_W-1:0] res_reg;

    logic [Q_W-1:0]        opa_mag, opb_mag;
    logic [SI_W-1:0]       num_mag;
    logic [DEN_W-1:0]      den_mag;
    logic [MAG_W-1:0]      div_q;
    logic [DEN_W:0]        div_r;
    logic signed [Q_W-1:0] sat_val;

    assign opa_mag = req.opa[Q_W-1] ? Q_W'(-req.opa) : Q_W'(req.opa);
    assign opb_mag = req.opb[Q_W-1] ? Q_W'(-req.opb) : Q_W'(req.opb);
    assign num_mag = req.num[SI_W-1] ? SI_W'(-req.num) : SI_W'(req.num);
    assign den_mag = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);

    // restoring division, eight quotient bits per cycle, remainder stays narrow
    always_comb
    begin
        div_q = mag_reg;
        div_r = {1'b0, rem_reg};
        for (int b = 0; b < DSTEPS; b++)
        begin
            div_r = {div_r[DEN_W-1:0], div_q[MAG_W-1]};
            div_q = {div_q[MAG_W-2:0], 1'b0};
            if (div_r >= {1'b0, d_reg})
            begin
                div_r    = div_r - {1'b0, d_reg};
                div_q[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (mag_reg > MAG_W'(1) << (Q_W - 1))
                sat_val = Q_MIN;
            else
                sat_val = Q_W'(-mag_reg);
        end
        else
        begin
            if (mag_reg > MAG_W'(Q_MAX))
                sat_val = Q_MAX;
            else
                sat_val = Q_W'(mag_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    state_next = A_MUL;
                    cnt_next   = '0;
                end
            end
            A_MUL:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(Q_W / CHUNK - 1))
                    state_next = A_ROUND;
            end
            A_ROUND:
            begin
                cnt_next   = '0;
                state_next = (op_reg == OP_MULQ) ? A_SAT : A_DIV;
            end
            A_DIV:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(MAG_W / DSTEPS - 1))
                    state_next = A_SAT;
            end
            A_SAT:   state_next = A_DONE;
            A_DONE:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done   = (state_reg == A_DONE);
        rsp.result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_reg   <= req.op;
                    ma_reg   <= opa_mag;
                    d_reg    <= den_mag;
                    prod_reg <= '0;
                    if (req.op == OP_MULQ)
                    begin
                        neg_reg <= req.opa[Q_W-1] ^ req.opb[Q_W-1];
                        mb_reg  <= opb_mag;
                    end
                    else
                    begin
                        neg_reg <= req.opa[Q_W-1] ^ req.num[SI_W-1] ^ req.den[DEN_W-1];
                        mb_reg  <= Q_W'(num_mag);
                    end
                end
            end
            A_MUL:
            begin
                // top chunk first: accumulate by shifting the partial sum up
                prod_reg <= {prod_reg[PROD_W-CHUNK-1:0], {CHUNK{1'b0}}}
                          + PROD_W'(ma_reg * mb_reg[Q_W-1 -: CHUNK]);
                mb_reg   <= {mb_reg[Q_W-CHUNK-1:0], {CHUNK{1'b0}}};
            end
            A_ROUND:
            begin
                rem_reg <= '0;
                if (op_reg == OP_MULQ)
                    mag_reg <= MAG_W'((prod_reg + (PROD_W'(1) << 31)) >> 32);
                else
                    mag_reg <= prod_reg[MAG_W-1:0] + MAG_W'(d_reg >> 1);
            end
            A_DIV:
            begin
                mag_reg <= div_q;
                rem_reg <= div_r[DEN_W-1:0];
            end
            A_SAT:
            begin
                res_reg <= sat_val;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[design/hermite_window_predictor_core.sv]
// The results of a window are computed one after another by the single shared multiply/divide
//   unit, which serves products and scales with division; no new samples are accepted while busy.
// Samples load one per cycle while idle. Results cannot be stalled by the receiver.
// Reset: registers return to 8 / 1 / 0, load count clears; stores keep old contents.
module hermite_window_predictor_core #(
    parameter int MAX_WINDOW  = hwp_pkg::MAX_WINDOW_DEF,
    parameter int MAX_OUTPUTS = hwp_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hwp_pkg::hwp_in_t               item,
    output logic                           result_strobe,
    output hwp_pkg::hwp_out_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hwp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hwp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hwp_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int ENT_W = 2 * SMP_W;

    // ---------------- configuration registers ----------------
    logic [5:0] window_size_reg;
    logic [6:0] output_count_reg;
    logic       reconstruct_reg;

    // ---------------- sequencer state ----------------
    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  n_reg, cnt_reg, start_pos_reg;
    logic [IDX_W-1:0]  i_reg, j_reg, m_reg;
    logic [LW-1:0]     load_count_reg;

    // ---------------- datapath registers ----------------
    logic signed [Q_W-1:0]    lag_reg, hsum_reg, sq_reg, a_reg, h1_reg, h2_reg, acc_reg;
    logic signed [PRED_W-1:0] pred_reg;
    logic                     last_reg;

    // window store: {sample, slope} per entry, one write and one registered read port
    logic [ENT_W-1:0] win_mem [MAX_WINDOW];
    logic [ENT_W-1:0] rd_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic             accept;
    logic             store_full;
    logic [IDX_W-1:0] n_eff, cnt_eff, ws_ext, k_pos;

    logic signed [SI_W-1:0]  k_s, j_s, m_s, km_s, jm_s, e_s, e2_s;
    logic signed [DEN_W-1:0] span_s;
    logic signed [Q_W-1:0]   y10, d10;
    logic [Q_W-1:0]          acc_mag, acc_rnd;
    logic signed [PRED_W-1:0] pred_next;

    assign accept     = start && !busy;
    assign store_full = (load_count_reg == LW'(MAX_WINDOW));
    assign cfg_ready  = 1'b1;

    // clamp the configured counts into range
    assign ws_ext = IDX_W'(window_size_reg);
    always_comb
    begin
        if (ws_ext < IDX_W'(2))
            n_eff = IDX_W'(2);
        else if (ws_ext > IDX_W'(MAX_WINDOW))
            n_eff = IDX_W'(MAX_WINDOW);
        else
            n_eff = ws_ext;

        if (output_count_reg == '0)
            cnt_eff = IDX_W'(1);
        else if (output_count_reg > IDX_W'(MAX_OUTPUTS))
            cnt_eff = IDX_W'(MAX_OUTPUTS);
        else
            cnt_eff = output_count_reg;
    end

    // position arithmetic on small signed integers
    assign k_pos  = start_pos_reg + i_reg;
    assign k_s    = $signed(SI_W'(k_pos));
    assign j_s    = $signed(SI_W'(j_reg));
    assign m_s    = $signed(SI_W'(m_reg));
    assign km_s   = k_s - m_s;
    assign jm_s   = j_s - m_s;
    assign e_s    = k_s - j_s;
    assign e2_s   = e_s <<< 1;
    assign span_s = $signed(DEN_W'(n_reg - IDX_W'(1)));

    // stored operands scaled into Q16.32
    assign y10 = {{(Q_W-SMP_W-10){rd_reg[ENT_W-1]}}, rd_reg[ENT_W-1 -: SMP_W], 10'b0};
    assign d10 = {{(Q_W-SMP_W-10){rd_reg[SMP_W-1]}}, rd_reg[SMP_W-1:0], 10'b0};

    // Q16.32 accumulator to Q10.22: round half away from zero, saturate
    assign acc_mag = acc_reg[Q_W-1] ? Q_W'(-acc_reg) : Q_W'(acc_reg);
    assign acc_rnd = (acc_mag + Q_W'(512)) >> 10;
    always_comb
    begin
        if (acc_reg[Q_W-1])
        begin
            if (acc_rnd > (Q_W'(1) << (PRED_W - 1)))
                pred_next = {1'b1, {(PRED_W-1){1'b0}}};
            else
                pred_next = PRED_W'(-acc_rnd);
        end
        else
        begin
            if (acc_rnd > Q_W'({1'b0, {(PRED_W-1){1'b1}}}))
                pred_next = {1'b0, {(PRED_W-1){1'b1}}};
            else
                pred_next = PRED_W'(acc_rnd);
        end
    end

    hwp_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && item.last_item)
                    state_next = ST_J_INIT;
            ST_J_INIT:
                state_next = ST_M_CHECK;
            ST_M_CHECK:
            begin
                if (m_reg == n_reg)
                    state_next = ST_SQ_GO;
                else if (m_reg != j_reg)
                    state_next = ST_LAG_GO;
            end
            ST_LAG_GO:   state_next = ST_LAG_WAIT;
            ST_LAG_WAIT: if (alu_rsp.done) state_next = ST_HS_GO;
            ST_HS_GO:    state_next = ST_HS_WAIT;
            ST_HS_WAIT:  if (alu_rsp.done) state_next = ST_M_CHECK;
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  if (alu_rsp.done) state_next = ST_AX_GO;
            ST_AX_GO:    state_next = ST_AX_WAIT;
            ST_AX_WAIT:  if (alu_rsp.done) state_next = ST_H1_GO;
            ST_H1_GO:    state_next = ST_H1_WAIT;
            ST_H1_WAIT:  if (alu_rsp.done) state_next = ST_H2_GO;
            ST_H2_GO:    state_next = ST_H2_WAIT;
            ST_H2_WAIT:  if (alu_rsp.done) state_next = ST_T1_GO;
            ST_T1_GO:    state_next = ST_T1_WAIT;
            ST_T1_WAIT:  if (alu_rsp.done) state_next = ST_T2_GO;
            ST_T2_GO:    state_next = ST_T2_WAIT;
            ST_T2_WAIT:
            begin
                if (alu_rsp.done)
                    state_next = (j_reg == n_reg - IDX_W'(1)) ? ST_ROUND : ST_J_INIT;
            end
            ST_ROUND:
                state_next = ST_EMIT;
            ST_EMIT:
                state_next = (i_reg == cnt_reg - IDX_W'(1)) ? ST_IDLE : ST_J_INIT;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs and unit requests ----------------
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        result_strobe = (state_reg == ST_EMIT);
        result.predicted = pred_reg;
        result.last_out  = last_reg;

        alu_req       = '0;
        alu_req.op    = OP_MULQ;
        case (state_reg)
            ST_LAG_GO:
            begin
                // L <- L * (k - m) / (j - m)
                alu_req.start = 1'b1;
                alu_req.op    = OP_SCALE;
                alu_req.opa   = lag_reg;
                alu_req.num   = km_s;
                alu_req.den   = DEN_W'(jm_s);
            end
            ST_HS_GO:
            begin
                // term of L_j'(x_j) / s: 1 / (j - m)
                alu_req.start = 1'b1;
                alu_req.op    = OP_SCALE;
                alu_req.opa   = Q_ONE;
                alu_req.num   = SI_W'(1);
                alu_req.den   = DEN_W'(jm_s);
            end
            ST_SQ_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.opa   = lag_reg;
                alu_req.opb   = lag_reg;
            end
            ST_AX_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_SCALE;
                alu_req.opa   = hsum_reg;
                alu_req.num   = e2_s;
                alu_req.den   = DEN_W'(1);
            end
            ST_H1_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.opa   = a_reg;
                alu_req.opb   = sq_reg;
            end
            ST_H2_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_SCALE;
                alu_req.opa   = sq_reg;
                alu_req.num   = e_s;
                alu_req.den   = span_s;
            end
            ST_T1_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.opa   = y10;
                alu_req.opb   = h1_reg;
            end
            ST_T2_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.opa   = d10;
                alu_req.opb   = h2_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_size_reg  <= 6'd8;
            output_count_reg <= 7'd1;
            reconstruct_reg  <= 1'b0;
            load_count_reg   <= '0;
            n_reg            <= IDX_W'(2);
            cnt_reg          <= IDX_W'(1);
            start_pos_reg    <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            m_reg            <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data[5:0];
                    CFG_OUTPUT_COUNT: output_count_reg <= cfg_data;
                    CFG_RECONSTRUCT:  reconstruct_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.last_item)
                        begin
                            load_count_reg <= '0;
                            n_reg          <= n_eff;
                            cnt_reg        <= cnt_eff;
                            start_pos_reg  <= reconstruct_reg ? '0 : n_eff;
                            i_reg          <= '0;
                            j_reg          <= '0;
                        end
                        else if (!store_full)
                        begin
                            load_count_reg <= load_count_reg + LW'(1);
                        end
                    end
                end
                ST_J_INIT:
                    m_reg <= '0;
                ST_M_CHECK:
                    if (m_reg != n_reg && m_reg == j_reg)
                        m_reg <= m_reg + IDX_W'(1);
                ST_HS_WAIT:
                    if (alu_rsp.done)
                        m_reg <= m_reg + IDX_W'(1);
                ST_T2_WAIT:
                    if (alu_rsp.done && j_reg != n_reg - IDX_W'(1))
                        j_reg <= j_reg + IDX_W'(1);
                ST_EMIT:
                begin
                    i_reg <= i_reg + IDX_W'(1);
                    j_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- window store ----------------
    always_ff @(posedge clk)
    begin
        if (accept && !store_full)
            win_mem[load_count_reg[AW-1:0]] <= {item.sample, item.slope};
        if (state_reg == ST_J_INIT)
            rd_reg <= win_mem[j_reg[AW-1:0]];
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                acc_reg <= '0;
            ST_J_INIT:
            begin
                lag_reg  <= Q_ONE;
                hsum_reg <= '0;
            end
            ST_LAG_WAIT:
                if (alu_rsp.done) lag_reg <= alu_rsp.result;
            ST_HS_WAIT:
                if (alu_rsp.done)
                    hsum_reg <= q_sat({hsum_reg[Q_W-1], hsum_reg}
                                      + {alu_rsp.result[Q_W-1], alu_rsp.result});
            ST_SQ_WAIT:
                if (alu_rsp.done) sq_reg <= alu_rsp.result;
            ST_AX_WAIT:
                // A = 1 - 2*(t - x_j)*L_j'(x_j)
                if (alu_rsp.done)
                    a_reg <= q_sat({Q_ONE[Q_W-1], Q_ONE}
                                   - {alu_rsp.result[Q_W-1], alu_rsp.result});
            ST_H1_WAIT:
                if (alu_rsp.done) h1_reg <= alu_rsp.result;
            ST_H2_WAIT:
                if (alu_rsp.done) h2_reg <= alu_rsp.result;
            ST_T1_WAIT, ST_T2_WAIT:
                if (alu_rsp.done)
                    acc_reg <= q_sat({acc_reg[Q_W-1], acc_reg}
                                     + {alu_rsp.result[Q_W-1], alu_rsp.result});
            ST_ROUND:
            begin
                pred_reg <= pred_next;
                last_reg <= (i_reg == cnt_reg - IDX_W'(1));
            end
            ST_EMIT:
                acc_reg <= '0;
            default:
            begin
            end
        endcase
    end

    // ---------------- checks ----------------
    a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe outside a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_out) |=> !busy)
        else $error("run continued past its final result");

    a_last_item_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_item) |=> (busy && load_count_reg == '0))
        else $error("final sample did not start a run");

    a_load_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (load_count_reg == '0))
        else $error("load count not cleared during run");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= LW'(MAX_WINDOW))
        else $error("load count beyond store depth");

endmodule
